// ----- rtl/core/lcvb_pkg.sv -----
// lcvb_pkg: sizes, payload types, control/status structs and helper functions
// for the cvb0 token update block; no dependencies
`default_nettype none

package lcvb_pkg;

    localparam int TOPICS    = 16;
    localparam int VOCAB     = 4096;
    localparam int MAX_DOCS  = 1024;
    localparam int MAX_SLOTS = 4096;

    localparam int TOPIC_W    = $clog2(TOPICS);
    localparam int RESP_DEPTH = MAX_SLOTS * TOPICS;
    localparam int WT_DEPTH   = VOCAB * TOPICS;
    localparam int DT_DEPTH   = MAX_DOCS * TOPICS;
    localparam int RESP_AW    = $clog2(RESP_DEPTH);
    localparam int WT_AW      = $clog2(WT_DEPTH);
    localparam int DT_AW      = $clog2(DT_DEPTH);
    localparam int CLR_DEPTH  = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam int CNT_W   = 40;
    localparam int RESP_W  = 17;
    localparam int WCNT_W  = 16;
    localparam int AMT_W   = WCNT_W + RESP_W;
    localparam int PRIOR_W = 24;
    localparam int VSZ_W   = 13;
    localparam int VE_W    = PRIOR_W + VSZ_W;
    localparam int AB_W    = CNT_W + 1;
    localparam int BSPLIT  = 21;
    localparam int PP_W    = AB_W + BSPLIT;
    localparam int PROD_W  = 2 * AB_W;
    localparam int WGT_W   = 48;
    localparam int WSUM_W  = WGT_W + $clog2(TOPICS);
    localparam int DIV_W   = WSUM_W;
    localparam int NQ_W    = $clog2(WGT_W + 1);
    localparam int PTOK_W  = 13;

    localparam logic [RESP_W-1:0] ONE_Q16   = RESP_W'(65536);
    localparam logic [RESP_W-1:0] RESP_EVEN = RESP_W'(65536 / TOPICS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [PTOK_W-1:0] PTOK_MAX  = '1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PRIOR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ETA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = CFG_IDX_W'(2);

    typedef struct packed {
        logic        opcode;
        logic [11:0] token_slot;
        logic [11:0] word_id;
        logic [9:0]  doc_id;
        logic [15:0] word_count;
        logic [3:0]  topic_sel;
        logic [16:0] resp_value;
        logic        pass_end;
    } in_item_t;

    typedef struct packed {
        logic        pass_done;
        logic [16:0] mean_change;
    } out_item_t;

    typedef enum logic [1:0] {
        AMT_OLD  = 2'd0,
        AMT_NEW  = 2'd1,
        AMT_LOAD = 2'd2
    } amt_sel_t;

    typedef enum logic [1:0] {
        DIV_WGT  = 2'd0,
        DIV_RSP  = 2'd1,
        DIV_MEAN = 2'd2
    } div_mode_t;

    typedef struct packed {
        logic      clr;
        logic      capture;
        logic      res_clr;
        logic      k_inc;
        logic      k_clr;
        logic      rd;
        logic      mul;
        amt_sel_t  amt_sel;
        logic      sub_wr;
        logic      mul_lo;
        logic      mul_hi;
        logic      add_prod;
        logic      div_start;
        div_mode_t div_mode;
        logic      wgt_store;
        logic      add_wr;
        logic      add_chg;
        logic      tok_inc;
        logic      mean_store;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op;
        logic tsel_ok;
        logic pend;
        logic k_last;
        logic wsum_zero;
        logic div_busy;
        logic out_busy;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] sub_floor(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lcvb_div.sv -----
// lcvb_div: shared restoring divider, one quotient bit per cycle
// depends on lcvb_pkg
`default_nettype none

module lcvb_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lcvb_pkg::DIV_W-1:0] rem_init,
    input  wire logic [lcvb_pkg::WGT_W-1:0] low_init,
    input  wire logic [lcvb_pkg::DIV_W-1:0] divisor,
    input  wire logic [lcvb_pkg::NQ_W-1:0]  nq,
    output logic                            busy,
    output logic [lcvb_pkg::WGT_W-1:0]      quo
);
    import lcvb_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [WGT_W-1:0] low_reg, quo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [NQ_W-1:0]  cnt_reg;
    logic [DIV_W:0]   r2, r2_sub;
    logic             ge;

    assign r2     = {rem_reg, low_reg[WGT_W-1]};
    assign r2_sub = r2 - {1'b0, dvs_reg};
    assign ge     = (r2 >= {1'b0, dvs_reg});
    assign rem_next = ge ? r2_sub[DIV_W-1:0] : r2[DIV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= nq;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - NQ_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            low_reg <= low_init;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[WGT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[WGT_W-2:0], ge};
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/lcvb_dp.sv -----
// lcvb_dp: datapath with responsibility and count stores, multipliers,
// accumulators, config registers and output register; uses lcvb_pkg, lcvb_div
`default_nettype none

module lcvb_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lcvb_pkg::ctrl_cmd_t             cmd,
    output lcvb_pkg::dp_status_t                 stat,
    input  wire lcvb_pkg::in_item_t              in_item,
    input  wire logic                            cfg_we,
    input  wire logic [lcvb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcvb_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                 out_valid,
    output lcvb_pkg::out_item_t                  out_item,
    input  wire logic                            out_stall
);
    import lcvb_pkg::*;

    // config
    logic [PRIOR_W-1:0] alpha_reg, eta_reg;
    logic [VSZ_W-1:0]   vocab_reg;
    logic [VE_W-1:0]    ve_reg;

    // captured item
    logic               op_reg, pend_reg, tsel_ok_reg;
    logic [11:0]        slot_reg, word_reg;
    logic [9:0]         doc_reg;
    logic [WCNT_W-1:0]  cnt_reg;
    logic [RESP_W-1:0]  rv_reg;
    logic [TOPIC_W-1:0] k_reg;

    // stores
    logic [RESP_W-1:0] resp_mem [RESP_DEPTH];
    logic [CNT_W-1:0]  wt_mem [WT_DEPTH];
    logic [CNT_W-1:0]  dt_mem [DT_DEPTH];
    logic [RESP_W-1:0] resp_q;
    logic [CNT_W-1:0]  wt_q, dt_q;
    logic [CNT_W-1:0]  tt_reg [TOPICS];
    logic [WGT_W-1:0]  wgt_reg [TOPICS];
    logic [CLR_W-1:0]  clr_reg;

    logic [RESP_AW-1:0] resp_addr;
    logic [WT_AW-1:0]   wt_row, wt_addr;
    logic [DT_AW-1:0]   dt_row, dt_addr;
    logic               wt_we, dt_we, resp_we;
    logic [CNT_W-1:0]   wt_wdata, dt_wdata, tt_wdata;
    logic [RESP_W-1:0]  resp_wdata;

    // arithmetic
    logic [AMT_W-1:0]   amt_reg, amt_mul;
    logic [RESP_W-1:0]  amt_src, nr, nr_reg, diff_reg;
    logic [CNT_W-1:0]   amt_ext, tt_cur;
    logic [CNT_W-1:0]   wt_sub, dt_sub, tt_sub;
    logic [AB_W-1:0]    a_reg, b_reg, c_reg, c_sum;
    logic [BSPLIT-1:0]  pp_b;
    logic [PP_W-1:0]    pp, pp0_reg, pp1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [CNT_W-1:0]   cs_reg;
    logic [PTOK_W-1:0]  ptok_reg;
    logic [WGT_W-1:0]   wgt_cur, wq, quo;
    logic [RESP_W-1:0]  mean;

    // divider operands
    logic [DIV_W-1:0] d_rem, d_dvs;
    logic [WGT_W-1:0] d_low;
    logic [NQ_W-1:0]  d_nq;
    logic             sat_reg, div_busy;

    // result
    logic              res_done_reg;
    logic [RESP_W-1:0] res_mean_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= PRIOR_W'(6554);
            eta_reg   <= PRIOR_W'(6554);
            vocab_reg <= VSZ_W'(4096);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_ETA:   eta_reg   <= cfg_data;
                CFG_VOCAB: vocab_reg <= cfg_data[VSZ_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ve_reg <= VE_W'(vocab_reg) * VE_W'(eta_reg);
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= in_item.opcode;
            pend_reg    <= in_item.pass_end;
            tsel_ok_reg <= (32'(in_item.topic_sel) < TOPICS);
            slot_reg    <= in_item.token_slot;
            word_reg    <= in_item.word_id;
            doc_reg     <= in_item.doc_id;
            cnt_reg     <= in_item.word_count;
            rv_reg      <= (in_item.resp_value > ONE_Q16) ? ONE_Q16 : in_item.resp_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cmd.capture)
        begin
            k_reg <= in_item.opcode ? '0 : TOPIC_W'(in_item.topic_sel);
        end
        else if (cmd.k_clr)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + TOPIC_W'(1);
        end
    end

    // clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_reg <= clr_reg + CLR_W'(1);
        end
    end

    // addresses
    assign resp_addr = RESP_AW'(slot_reg * TOPICS) + RESP_AW'(k_reg);
    assign wt_row    = WT_AW'(word_reg * TOPICS) + WT_AW'(k_reg);
    assign dt_row    = DT_AW'(doc_reg * TOPICS) + DT_AW'(k_reg);
    assign wt_addr   = cmd.clr ? WT_AW'(clr_reg) : wt_row;
    assign dt_addr   = cmd.clr ? DT_AW'(clr_reg) : dt_row;

    assign amt_ext = CNT_W'(amt_reg);
    assign tt_cur  = tt_reg[k_reg];
    assign wt_sub  = sub_floor(wt_q, amt_ext);
    assign dt_sub  = sub_floor(dt_q, amt_ext);
    assign tt_sub  = sub_floor(tt_cur, amt_ext);

    assign wt_we    = cmd.clr ? (32'(clr_reg) < WT_DEPTH) : (cmd.sub_wr || cmd.add_wr);
    assign dt_we    = cmd.clr ? (32'(clr_reg) < DT_DEPTH) : (cmd.sub_wr || cmd.add_wr);
    assign wt_wdata = cmd.clr ? '0 : (cmd.sub_wr ? wt_sub : add_sat(wt_q, amt_ext));
    assign dt_wdata = cmd.clr ? '0 : (cmd.sub_wr ? dt_sub : add_sat(dt_q, amt_ext));
    assign tt_wdata = cmd.sub_wr ? tt_sub : add_sat(tt_cur, amt_ext);
    assign resp_we    = cmd.add_wr;
    assign resp_wdata = cmd.add_chg ? nr_reg : rv_reg;

    always_ff @(posedge clk)
    begin
        if (resp_we)
        begin
            resp_mem[resp_addr] <= resp_wdata;
        end
        if (cmd.rd)
        begin
            resp_q <= resp_mem[resp_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[wt_addr] <= wt_wdata;
        end
        if (cmd.rd)
        begin
            wt_q <= wt_mem[wt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            dt_mem[dt_addr] <= dt_wdata;
        end
        if (cmd.rd)
        begin
            dt_q <= dt_mem[dt_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOPICS; i++)
            begin
                tt_reg[i] <= '0;
            end
        end
        else if (cmd.sub_wr || cmd.add_wr)
        begin
            tt_reg[k_reg] <= tt_wdata;
        end
    end

    // weighted count multiplier
    always_comb
    begin
        case (cmd.amt_sel)
            AMT_OLD:  amt_src = resp_q;
            AMT_NEW:  amt_src = nr;
            AMT_LOAD: amt_src = rv_reg;
            default:  amt_src = resp_q;
        endcase
    end

    assign amt_mul = AMT_W'(cnt_reg) * AMT_W'(amt_src);
    assign nr      = stat.wsum_zero ? RESP_EVEN : quo[RESP_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            amt_reg  <= amt_mul;
            nr_reg   <= nr;
            diff_reg <= (nr > resp_q) ? (nr - resp_q) : (resp_q - nr);
        end
    end

    // smoothed sums
    assign c_sum = AB_W'(ve_reg) + AB_W'(tt_sub);

    always_ff @(posedge clk)
    begin
        if (cmd.sub_wr)
        begin
            a_reg <= AB_W'(eta_reg) + AB_W'(wt_sub);
            b_reg <= AB_W'(alpha_reg) + AB_W'(dt_sub);
            c_reg <= (c_sum == '0) ? AB_W'(1) : c_sum;
        end
    end

    // 41x41 product in two partial products
    assign pp_b = cmd.mul_hi ? BSPLIT'(b_reg[AB_W-1:BSPLIT]) : b_reg[BSPLIT-1:0];
    assign pp   = PP_W'(a_reg) * PP_W'(pp_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            pp0_reg <= pp;
        end
        if (cmd.mul_hi)
        begin
            pp1_reg <= pp;
        end
        if (cmd.add_prod)
        begin
            prod_reg <= PROD_W'(pp0_reg) + (PROD_W'(pp1_reg) << BSPLIT);
        end
    end

    // divider operands
    assign wgt_cur = wgt_reg[k_reg];

    always_comb
    begin
        case (cmd.div_mode)
            DIV_WGT:
            begin
                d_rem = DIV_W'(prod_reg[PROD_W-1:WGT_W]);
                d_low = prod_reg[WGT_W-1:0];
                d_dvs = DIV_W'(c_reg);
                d_nq  = NQ_W'(WGT_W);
            end
            DIV_RSP:
            begin
                d_rem = DIV_W'(wgt_cur[WGT_W-1:1]);
                d_low = {wgt_cur[0], {(WGT_W-1){1'b0}}};
                d_dvs = wsum_reg;
                d_nq  = NQ_W'(RESP_W);
            end
            DIV_MEAN:
            begin
                d_rem = DIV_W'(cs_reg[CNT_W-1:RESP_W]);
                d_low = {cs_reg[RESP_W-1:0], {(WGT_W-RESP_W){1'b0}}};
                d_dvs = DIV_W'(ptok_reg * TOPICS);
                d_nq  = NQ_W'(RESP_W);
            end
            default:
            begin
                d_rem = DIV_W'(prod_reg[PROD_W-1:WGT_W]);
                d_low = prod_reg[WGT_W-1:0];
                d_dvs = DIV_W'(c_reg);
                d_nq  = NQ_W'(WGT_W);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            sat_reg <= (d_rem >= d_dvs);
        end
    end

    lcvb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .rem_init (d_rem),
        .low_init (d_low),
        .divisor  (d_dvs),
        .nq       (d_nq),
        .busy     (div_busy),
        .quo      (quo)
    );

    // weights and their sum
    assign wq = sat_reg ? '1 : quo;

    always_ff @(posedge clk)
    begin
        if (cmd.wgt_store)
        begin
            wgt_reg[k_reg] <= wq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0;
        end
        else if (cmd.capture)
        begin
            wsum_reg <= '0;
        end
        else if (cmd.wgt_store)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(wq);
        end
    end

    // pass statistics
    assign mean = sat_reg ? ONE_Q16
                : ((quo[RESP_W-1:0] > ONE_Q16) ? ONE_Q16 : quo[RESP_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_reg   <= '0;
            ptok_reg <= '0;
        end
        else if (cmd.mean_store)
        begin
            cs_reg   <= '0;
            ptok_reg <= '0;
        end
        else
        begin
            if (cmd.add_wr && cmd.add_chg)
            begin
                cs_reg <= add_sat(cs_reg, CNT_W'(diff_reg));
            end
            if (cmd.tok_inc && (ptok_reg != PTOK_MAX))
            begin
                ptok_reg <= ptok_reg + PTOK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_done_reg <= 1'b0;
            res_mean_reg <= '0;
        end
        else if (cmd.res_clr)
        begin
            res_done_reg <= 1'b0;
            res_mean_reg <= '0;
        end
        else if (cmd.mean_store)
        begin
            res_done_reg <= 1'b1;
            res_mean_reg <= mean;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.pass_done   <= res_done_reg;
            out_item_reg.mean_change <= res_mean_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign stat.clr_last  = (32'(clr_reg) == CLR_DEPTH - 1);
    assign stat.op        = op_reg;
    assign stat.tsel_ok   = tsel_ok_reg;
    assign stat.pend      = pend_reg;
    assign stat.k_last    = (k_reg == TOPIC_W'(TOPICS - 1));
    assign stat.wsum_zero = (wsum_reg == '0);
    assign stat.div_busy  = div_busy;
    assign stat.out_busy  = out_valid_reg && out_stall;

endmodule

`default_nettype wire

// ----- rtl/core/lcvb_ctrl.sv -----
// lcvb_ctrl: sequencer for clearing, load and two-sweep update of one token
// depends on lcvb_pkg
`default_nettype none

module lcvb_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    output lcvb_pkg::ctrl_cmd_t       cmd,
    input  wire lcvb_pkg::dp_status_t stat
);
    import lcvb_pkg::*;

    typedef enum logic [24:0] {
        S_CLEAR = 25'd1 << 0,
        S_IDLE  = 25'd1 << 1,
        S_DISP  = 25'd1 << 2,
        S_LRD   = 25'd1 << 3,
        S_LMUL  = 25'd1 << 4,
        S_LWR   = 25'd1 << 5,
        S_URD   = 25'd1 << 6,
        S_UMUL  = 25'd1 << 7,
        S_USUB  = 25'd1 << 8,
        S_UMLO  = 25'd1 << 9,
        S_UMHI  = 25'd1 << 10,
        S_UADD  = 25'd1 << 11,
        S_UDIV  = 25'd1 << 12,
        S_UWAIT = 25'd1 << 13,
        S_UWST  = 25'd1 << 14,
        S_RRD   = 25'd1 << 15,
        S_RDIV  = 25'd1 << 16,
        S_RWAIT = 25'd1 << 17,
        S_RMUL  = 25'd1 << 18,
        S_RWR   = 25'd1 << 19,
        S_TOK   = 25'd1 << 20,
        S_MDIV  = 25'd1 << 21,
        S_MWAIT = 25'd1 << 22,
        S_MEND  = 25'd1 << 23,
        S_FIN   = 25'd1 << 24
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.res_clr = 1'b1;
                if (stat.op)
                begin
                    state_next = S_URD;
                end
                else if (stat.tsel_ok)
                begin
                    state_next = S_LRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_LRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_LMUL;
            end
            S_LMUL:
            begin
                cmd.mul     = 1'b1;
                cmd.amt_sel = AMT_LOAD;
                state_next  = S_LWR;
            end
            S_LWR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_FIN;
            end
            S_URD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.mul     = 1'b1;
                cmd.amt_sel = AMT_OLD;
                state_next  = S_USUB;
            end
            S_USUB:
            begin
                cmd.sub_wr = 1'b1;
                state_next = S_UMLO;
            end
            S_UMLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_UMHI;
            end
            S_UMHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_UADD;
            end
            S_UADD:
            begin
                cmd.add_prod = 1'b1;
                state_next   = S_UDIV;
            end
            S_UDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_WGT;
                state_next    = S_UWAIT;
            end
            S_UWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_UWST;
                end
            end
            S_UWST:
            begin
                cmd.wgt_store = 1'b1;
                if (stat.k_last)
                begin
                    cmd.k_clr  = 1'b1;
                    state_next = S_RRD;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_URD;
                end
            end
            S_RRD:
            begin
                cmd.rd     = 1'b1;
                state_next = stat.wsum_zero ? S_RMUL : S_RDIV;
            end
            S_RDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_RSP;
                state_next    = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_RMUL;
                end
            end
            S_RMUL:
            begin
                cmd.mul     = 1'b1;
                cmd.amt_sel = AMT_NEW;
                state_next  = S_RWR;
            end
            S_RWR:
            begin
                cmd.add_wr  = 1'b1;
                cmd.add_chg = 1'b1;
                if (stat.k_last)
                begin
                    state_next = S_TOK;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_RRD;
                end
            end
            S_TOK:
            begin
                cmd.tok_inc = 1'b1;
                state_next  = stat.pend ? S_MDIV : S_FIN;
            end
            S_MDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_MEAN;
                state_next    = S_MWAIT;
            end
            S_MWAIT:
            begin
                cmd.div_mode = DIV_MEAN;
                if (!stat.div_busy)
                begin
                    state_next = S_MEND;
                end
            end
            S_MEND:
            begin
                cmd.mean_store = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/lda_cvb0_token_update.sv -----
// cvb0 token update top level: controller plus datapath. An update runs a
// weight sweep and then a normalize sweep over the 16 topics, plus a mean
// division at a pass end; a load writes one topic's counts. The 1-bit-per-cycle
// shared divider serves these divisions. One transaction is in work at a time.
// After reset a clearing sweep zeroes the count tables;
// in_stall is high meanwhile.
`default_nettype none

module lda_cvb0_token_update (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire lcvb_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output lcvb_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_we,
    input  wire logic [lcvb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcvb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lcvb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    lcvb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    lcvb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lcvb_checker.sv -----
// lcvb_checker: port-level assertions for the cvb0 token update block
// depends on lcvb_pkg; bound to lda_cvb0_token_update
`default_nettype none

module lcvb_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire lcvb_pkg::out_item_t out_item
);
    import lcvb_pkg::*;

    // held result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // one transaction in work at a time
    a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

    a_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.pass_done || out_item.mean_change == '0))
        else $error("mean reported without pass end");

    a_mean_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.mean_change <= ONE_Q16))
        else $error("mean above one");

endmodule

bind lda_cvb0_token_update lcvb_checker u_lcvb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
